// ===== sv/bba_pkg.sv =====
// Shared types and constants for the buddy block allocator.
package bba_pkg;

	localparam int POOL_LIMIT_LOG2 = 24;

	localparam logic [4:0] BSZ_RESET = 5'd4;
	localparam logic [3:0] CNT_RESET = 4'd10;

	localparam logic [1:0] MARK_UNUSED = 2'd0;
	localparam logic [1:0] MARK_ALLOC  = 2'd1;
	localparam logic [1:0] MARK_LISTED = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR = 2'd2;
	localparam logic [1:0] ST_BAD_CFG  = 2'd3;

	localparam logic [4:0] OP_NOP   = 5'd0;
	localparam logic [4:0] OP_CLEAR = 5'd1;
	localparam logic [4:0] OP_ROOT  = 5'd2;
	localparam logic [4:0] OP_LOAD  = 5'd3;
	localparam logic [4:0] OP_START = 5'd4;
	localparam logic [4:0] OP_SCAN  = 5'd5;
	localparam logic [4:0] OP_URD   = 5'd6;
	localparam logic [4:0] OP_UWR   = 5'd7;
	localparam logic [4:0] OP_SPLIT = 5'd8;
	localparam logic [4:0] OP_PUSH1 = 5'd9;
	localparam logic [4:0] OP_PUSH2 = 5'd10;
	localparam logic [4:0] OP_AFIN  = 5'd11;
	localparam logic [4:0] OP_FRD   = 5'd12;
	localparam logic [4:0] OP_FCHK  = 5'd13;
	localparam logic [4:0] OP_MRD   = 5'd14;
	localparam logic [4:0] OP_MCHK  = 5'd15;
	localparam logic [4:0] OP_MUP   = 5'd16;
	localparam logic [4:0] OP_ERR   = 5'd17;
	localparam logic [4:0] OP_EMIT  = 5'd18;

	typedef struct packed {
		logic [4:0] op;
		logic [1:0] err;
	} cmd_t;

	typedef struct packed {
		logic bad_cfg;
		logic is_free;
		logic start_ok;
		logic lv_over;
		logic head_ok;
		logic lv_gt_want;
		logic mark_alloc;
		logic mark_listed;
		logic lv_zero;
		logic node_zero;
		logic clr_last;
	} sts_t;

endpackage

// ===== sv/bba_dp.sv =====
// Datapath of the buddy allocator: config, node memories, level heads, result.
module bba_dp #(
	parameter int MAX_BLOCKS_LOG2 = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bba_pkg::cmd_t cmd,
	output bba_pkg::sts_t sts,
	input  logic          cfg_wr,
	input  logic          cfg_sel,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	input  logic          kind,
	input  logic [24:0]   req_size,
	input  logic [23:0]   req_address,
	output logic [1:0]    status,
	output logic [23:0]   grant_address,
	output logic [24:0]   granted_size
);
	import bba_pkg::*;

	localparam int NW = MAX_BLOCKS_LOG2 + 1;
	localparam int AW = NW + 1;
	localparam int NODE_DEPTH = (2 ** NW) - 1;
	localparam int LEVELS = MAX_BLOCKS_LOG2 + 1;
	localparam int LW = $clog2(MAX_BLOCKS_LOG2 + 2);
	localparam logic [NW-1:0] NIL = '1;

	logic [4:0]    bsz_q;
	logic [3:0]    cnt_q;
	logic [NW-1:0] clr_q;
	logic [NW-1:0] head_q [LEVELS];

	logic          kind_q;
	logic [24:0]   size_q;
	logic [23:0]   addr_q;
	logic [NW-1:0] node_q, u_q, h_q;
	logic [LW-1:0] lv_q, want_q;
	logic [1:0]    res_status_q;
	logic [23:0]   res_addr_q;
	logic [24:0]   res_size_q;

	logic [1:0]    mark_mem [NODE_DEPTH];
	logic [NW-1:0] prev_mem [NODE_DEPTH];
	logic [NW-1:0] next_mem [NODE_DEPTH];
	logic [1:0]    mark_rd_q;
	logic [NW-1:0] prev_rd_q, next_rd_q;

	logic          mark_we, prev_we, next_we;
	logic [NW-1:0] mark_wa, prev_wa, next_wa, mark_ra, pn_ra;
	logic [1:0]    mark_wd;
	logic [NW-1:0] prev_wd, next_wd;

	logic          cfg_ok;
	logic [24:0]   size_m1;
	logic [4:0]    cl, want_full;
	logic          size_found;
	logic [23:0]   lo_mask, blk_full;
	logic          addr_ok;
	logic [NW-2:0] bk;
	logic [LW-1:0] tz, f_lv;
	logic [NW-1:0] f_node, head_cur, bud;
	logic [AW-1:0] a_blk;

	assign cfg_ok = (bsz_q <= 5'(POOL_LIMIT_LOG2)) && (6'(cnt_q) <= 6'(MAX_BLOCKS_LOG2)) &&
		((6'(bsz_q) + 6'(cnt_q)) <= 6'(POOL_LIMIT_LOG2));

	always_comb begin
		size_m1 = (size_q == 25'd0) ? 25'd0 : size_q - 25'd1;
		cl = 5'd0;
		for (int i = 0; i < 25; i++) begin
			if (size_m1[i]) cl = 5'(i + 1);
		end
		want_full = (cl > bsz_q) ? cl - bsz_q : 5'd0;
		size_found = 6'(want_full) <= 6'(cnt_q);
	end

	always_comb begin
		lo_mask = (24'd1 << bsz_q) - 24'd1;
		blk_full = addr_q >> bsz_q;
		addr_ok = ((addr_q & lo_mask) == 24'd0) && (blk_full < (24'd1 << cnt_q));
		bk = blk_full[NW-2:0];
		tz = '0;
		for (int i = NW - 2; i >= 0; i--) begin
			if (bk[i]) tz = LW'(i);
		end
		f_lv = (bk == '0) ? LW'(cnt_q) : tz;
		f_node = (((NW'(1) << cnt_q) + NW'(bk)) >> f_lv) - NW'(1);
	end

	always_comb begin
		head_cur = NIL;
		for (int i = 0; i < LEVELS; i++) begin
			if (lv_q == LW'(i)) head_cur = head_q[i];
		end
	end

	assign bud = node_q[0] ? node_q + NW'(1) : node_q - NW'(1);
	assign a_blk = ((AW'(node_q) + AW'(1)) << lv_q) - (AW'(1) << cnt_q);

	always_comb begin
		sts.bad_cfg     = !cfg_ok;
		sts.is_free     = kind_q;
		sts.start_ok    = kind_q ? addr_ok : size_found;
		sts.lv_over     = 6'(lv_q) > 6'(cnt_q);
		sts.head_ok     = head_cur != NIL;
		sts.lv_gt_want  = lv_q > want_q;
		sts.mark_alloc  = mark_rd_q == MARK_ALLOC;
		sts.mark_listed = mark_rd_q == MARK_LISTED;
		sts.lv_zero     = lv_q == '0;
		sts.node_zero   = node_q == '0;
		sts.clr_last    = clr_q == NW'(NODE_DEPTH - 1);
	end

	always_comb begin
		mark_we = 1'b0;
		mark_wa = node_q;
		mark_wd = MARK_UNUSED;
		prev_we = 1'b0;
		prev_wa = u_q;
		prev_wd = NIL;
		next_we = 1'b0;
		next_wa = u_q;
		next_wd = NIL;
		mark_ra = node_q;
		pn_ra   = u_q;
		case (cmd.op)
			OP_CLEAR: begin
				mark_we = 1'b1;
				mark_wa = clr_q;
			end
			OP_ROOT: begin
				mark_we = 1'b1;
				mark_wa = '0;
				mark_wd = cfg_ok ? MARK_LISTED : MARK_UNUSED;
				prev_we = 1'b1;
				prev_wa = '0;
				next_we = 1'b1;
				next_wa = '0;
			end
			OP_UWR: begin
				mark_we = 1'b1;
				mark_wa = u_q;
				next_we = prev_rd_q != NIL;
				next_wa = prev_rd_q;
				next_wd = next_rd_q;
				prev_we = next_rd_q != NIL;
				prev_wa = next_rd_q;
				prev_wd = prev_rd_q;
			end
			OP_PUSH1: begin
				mark_we = 1'b1;
				mark_wa = u_q;
				mark_wd = MARK_LISTED;
				prev_we = 1'b1;
				next_we = 1'b1;
				next_wd = head_cur;
			end
			OP_PUSH2: begin
				prev_we = h_q != NIL;
				prev_wa = h_q;
				prev_wd = u_q;
			end
			OP_AFIN: begin
				mark_we = 1'b1;
				mark_wd = MARK_ALLOC;
			end
			OP_FCHK: begin
				mark_we = mark_rd_q == MARK_ALLOC;
			end
			OP_MRD: begin
				mark_ra = bud;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mark_we) mark_mem[mark_wa] <= mark_wd;
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		if (next_we) next_mem[next_wa] <= next_wd;
		mark_rd_q <= mark_mem[mark_ra];
		prev_rd_q <= prev_mem[pn_ra];
		next_rd_q <= next_mem[pn_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsz_q <= BSZ_RESET;
			cnt_q <= CNT_RESET;
			clr_q <= '0;
			for (int i = 0; i < LEVELS; i++) head_q[i] <= NIL;
		end else if (cfg_wr) begin
			if (cfg_sel) cnt_q <= pwdata[3:0];
			else bsz_q <= pwdata[4:0];
			clr_q <= '0;
		end else begin
			case (cmd.op)
				OP_CLEAR: clr_q <= clr_q + NW'(1);
				OP_ROOT: begin
					for (int i = 0; i < LEVELS; i++) begin
						head_q[i] <= (cfg_ok && 6'(cnt_q) == 6'(i)) ? '0 : NIL;
					end
				end
				OP_UWR: begin
					for (int i = 0; i < LEVELS; i++) begin
						if (lv_q == LW'(i) && prev_rd_q == NIL) head_q[i] <= next_rd_q;
					end
				end
				OP_PUSH1: begin
					for (int i = 0; i < LEVELS; i++) begin
						if (lv_q == LW'(i)) head_q[i] <= u_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				kind_q       <= kind;
				size_q       <= req_size;
				addr_q       <= req_address;
				res_status_q <= ST_OK;
				res_addr_q   <= '0;
				res_size_q   <= '0;
			end
			OP_START: begin
				if (kind_q) begin
					lv_q   <= f_lv;
					node_q <= f_node;
				end else begin
					lv_q   <= LW'(want_full);
					want_q <= LW'(want_full);
				end
			end
			OP_SCAN: begin
				if (head_cur != NIL) begin
					node_q <= head_cur;
					u_q    <= head_cur;
				end else begin
					lv_q <= lv_q + LW'(1);
				end
			end
			OP_SPLIT: begin
				lv_q   <= lv_q - LW'(1);
				node_q <= {node_q[NW-2:0], 1'b1};
				u_q    <= {node_q[NW-2:0], 1'b1} + NW'(1);
			end
			OP_PUSH1: h_q <= head_cur;
			OP_AFIN: begin
				res_addr_q <= 24'(a_blk) << bsz_q;
				res_size_q <= 25'd1 << (bsz_q + 5'(want_q));
			end
			OP_FCHK: begin
				if (mark_rd_q != MARK_ALLOC && lv_q != '0) begin
					node_q <= {node_q[NW-2:0], 1'b1};
					lv_q   <= lv_q - LW'(1);
				end
			end
			OP_MRD: u_q <= (node_q == '0) ? node_q : bud;
			OP_MCHK: begin
				if (mark_rd_q != MARK_LISTED) u_q <= node_q;
			end
			OP_MUP: begin
				node_q <= (node_q - NW'(1)) >> 1;
				lv_q   <= lv_q + LW'(1);
			end
			OP_ERR: res_status_q <= cmd.err;
			OP_EMIT: begin
				status        <= res_status_q;
				grant_address <= res_addr_q;
				granted_size  <= res_size_q;
			end
			default: begin
			end
		endcase
	end

	assign prdata = cfg_sel ? {28'd0, cnt_q} : {27'd0, bsz_q};

endmodule

// ===== sv/bba_ctrl.sv =====
// Sequencer of the buddy allocator: handshakes and per-request command stream.
module bba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  logic          cfg_wr,
	input  bba_pkg::sts_t sts,
	output bba_pkg::cmd_t cmd
);
	import bba_pkg::*;

	localparam logic [4:0] S_CLEAR = 5'd0;
	localparam logic [4:0] S_ROOT  = 5'd1;
	localparam logic [4:0] S_IDLE  = 5'd2;
	localparam logic [4:0] S_START = 5'd3;
	localparam logic [4:0] S_SCAN  = 5'd4;
	localparam logic [4:0] S_URD   = 5'd5;
	localparam logic [4:0] S_UWR   = 5'd6;
	localparam logic [4:0] S_SPLIT = 5'd7;
	localparam logic [4:0] S_PUSH1 = 5'd8;
	localparam logic [4:0] S_PUSH2 = 5'd9;
	localparam logic [4:0] S_AFIN  = 5'd10;
	localparam logic [4:0] S_FRD   = 5'd11;
	localparam logic [4:0] S_FCHK  = 5'd12;
	localparam logic [4:0] S_MRD   = 5'd13;
	localparam logic [4:0] S_MCHK  = 5'd14;
	localparam logic [4:0] S_MUP   = 5'd15;
	localparam logic [4:0] S_ERR   = 5'd16;
	localparam logic [4:0] S_DONE  = 5'd17;

	logic [4:0] state_q, state_d;
	logic [1:0] err_q, err_d;
	logic       out_valid_q;

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		err_d   = err_q;
		cmd.op  = OP_NOP;
		cmd.err = err_q;
		case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (sts.clr_last) state_d = S_ROOT;
			end
			S_ROOT: begin
				cmd.op  = OP_ROOT;
				state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_START;
				end
			end
			S_START: begin
				cmd.op = OP_START;
				if (sts.bad_cfg) begin
					err_d   = ST_BAD_CFG;
					state_d = S_ERR;
				end else if (!sts.start_ok) begin
					err_d   = sts.is_free ? ST_BAD_ADDR : ST_NO_SPACE;
					state_d = S_ERR;
				end else begin
					state_d = sts.is_free ? S_FRD : S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.lv_over) begin
					err_d   = ST_NO_SPACE;
					state_d = S_ERR;
				end else begin
					cmd.op = OP_SCAN;
					if (sts.head_ok) state_d = S_URD;
				end
			end
			S_URD: begin
				cmd.op  = OP_URD;
				state_d = S_UWR;
			end
			S_UWR: begin
				cmd.op  = OP_UWR;
				state_d = sts.is_free ? S_MUP : S_SPLIT;
			end
			S_SPLIT: begin
				if (sts.lv_gt_want) begin
					cmd.op  = OP_SPLIT;
					state_d = S_PUSH1;
				end else begin
					state_d = S_AFIN;
				end
			end
			S_PUSH1: begin
				cmd.op  = OP_PUSH1;
				state_d = S_PUSH2;
			end
			S_PUSH2: begin
				cmd.op  = OP_PUSH2;
				state_d = sts.is_free ? S_DONE : S_SPLIT;
			end
			S_AFIN: begin
				cmd.op  = OP_AFIN;
				state_d = S_DONE;
			end
			S_FRD: begin
				cmd.op  = OP_FRD;
				state_d = S_FCHK;
			end
			S_FCHK: begin
				cmd.op = OP_FCHK;
				if (sts.mark_alloc) begin
					state_d = S_MRD;
				end else if (sts.lv_zero) begin
					err_d   = ST_BAD_ADDR;
					state_d = S_ERR;
				end else begin
					state_d = S_FRD;
				end
			end
			S_MRD: begin
				cmd.op  = OP_MRD;
				state_d = sts.node_zero ? S_PUSH1 : S_MCHK;
			end
			S_MCHK: begin
				cmd.op  = OP_MCHK;
				state_d = sts.mark_listed ? S_URD : S_PUSH1;
			end
			S_MUP: begin
				cmd.op  = OP_MUP;
				state_d = S_MRD;
			end
			S_ERR: begin
				cmd.op  = OP_ERR;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
		if (cfg_wr) state_d = S_CLEAR;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			err_q   <= err_d;
			if (cmd.op == OP_EMIT) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !out_valid_q) |=> out_valid_q)
		else $error("finished word not presented");

	a_start_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_START) |-> ($past(state_q) == S_IDLE))
		else $error("request started without acceptance");

	a_clear_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && !sts.clr_last) |=> (state_q == S_CLEAR))
		else $error("clearing pass left early");

endmodule

// ===== sv/buddy_block_allocator.sv =====
// Top level of the binary buddy allocator.
//
// Input channel (in_valid/in_stall) carries one request word: kind selects
// allocate or free, req_size and req_address give its operand. Output channel
// (out_valid/out_stall) returns one result word per request not aborted by a
// config write: status, grant_address and granted_size. The APB port writes
// block_size_log2 at 0 and block_count_log2 at 4; any write rebuilds the pool.
//
// Requests are handled one at a time by a sequencer over node memories
// (mark, prev, next) that each have a separate read and write port. An
// allocate scans the level lists upward from the wanted level, unlinks the
// block it finds and splits it down level by level, pushing the other half
// onto its level list. A free walks down to find the allocated node, then
// merges it with free buddies level by level upward. Reset and every config
// write start a clearing pass through the mark memory; no request is taken
// meanwhile. A stalled result is held in the output register; the next
// request is still accepted and runs until its own result is ready.
module buddy_block_allocator #(
	parameter int MAX_BLOCKS_LOG2 = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [24:0] req_size,
	input  logic [23:0] req_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [23:0] grant_address,
	output logic [24:0] granted_size,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bba_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_wr    (cfg_wr),
		.sts       (sts),
		.cmd       (cmd)
	);

	bba_dp #(
		.MAX_BLOCKS_LOG2(MAX_BLOCKS_LOG2)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_wr        (cfg_wr),
		.cfg_sel       (paddr[2]),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.kind          (kind),
		.req_size      (req_size),
		.req_address   (req_address),
		.status        (status),
		.grant_address (grant_address),
		.granted_size  (granted_size)
	);

endmodule
